// File: rtl/gb2312_pinyin_initial_encoder_assert.svh
// Assertion helpers used by the checker file of the pinyin initial encoder.
`ifndef GB2312_PINYIN_INITIAL_ENCODER_ASSERT_SVH
`define GB2312_PINYIN_INITIAL_ENCODER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define GPIE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define GPIE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gpie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpie_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    // Byte codes
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DASH  = 8'h2d;
    localparam logic [7:0] CHR_STAR  = 8'h2a;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_LC_A  = 8'h61;
    localparam logic [7:0] CHR_LC_Z  = 8'h7a;
    localparam logic [7:0] CASE_GAP  = 8'h20;
    localparam logic [7:0] LEAD_MIN  = 8'ha1;

    // Zone/position code arithmetic
    localparam int ZONE_BIAS  = 160;
    localparam int ZONE_MUL   = 100;
    localparam int DIGIT_LO   = 316;
    localparam int DIGIT_HI   = 325;
    localparam int LETTER_LO  = 333;
    localparam int LETTER_HI  = 358;
    localparam int L1_LO      = 1601;
    localparam int L1_END     = 5590;
    localparam int L2_ROW0    = 56;
    localparam int L2_ROW_LEN = 94;
    localparam int L2_COL0    = 161;
    localparam int L2_MAX     = 3007;
    localparam int L2_IDX_W   = $clog2(L2_MAX + 1);
    localparam int CODE_W     = 14;

    localparam int NUM_BOUNDS = 23;

    localparam logic [CODE_W-1:0] BOUND_CODE [NUM_BOUNDS] = '{
        14'd1601, 14'd1637, 14'd1833, 14'd2078, 14'd2274, 14'd2302, 14'd2433, 14'd2594,
        14'd2787, 14'd3106, 14'd3212, 14'd3472, 14'd3635, 14'd3722, 14'd3730, 14'd3858,
        14'd4027, 14'd4086, 14'd4390, 14'd4558, 14'd4684, 14'd4925, 14'd5249
    };

    localparam logic [7:0] BOUND_LETTER [NUM_BOUNDS] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M",
        "N", "O", "P", "Q", "R", "S", "T", "W", "X", "Y", "Z"
    };

    // Level-2 initials, first entry in the top byte
    localparam L2_ROM = {
        "cjwgnspgcgne[y[btyyzdxykygt[jnnjqmbsgzscyjsyy[pgkbzgy[ywjkgkljywkpjqhy[w[dzlsgmrypywwcckznk",
        "yygttnjjnykkzytcjnmcylqlypyqfqrpzslwbtgkjfyxjwzltbncxjjjjtxdttsqzycdxxhgck[phffss[ybgxlppbyll",
        "[hlxs[zm[jhsojnghdzqyklgjhsgqzhxqgkezzwyscscjxyeyxadzpmdssmzjzqjyzc[j[wqjbyzpxgznzcpwhkxhqkmw",
        "fbpbydtjzzkqhy",
        "lygxfptyjyyzpszlfchmqshgmxxsxj[[dcsbbqbefsjyhxwgzkpylqbgldlcctnmayddkssngycsgxlyzaybnptsdkd",
        "ylhgymylcxpy[jndqjwxqxfyyfjlejpzrxccqwqqsbnkymgplbmjrqcflnymyqmsqyrbcjthztqfrxqhxmjjcjlxqgjm",
        "shzkbswyemyltxfsydswlycjqxsjnqbsctyhbftdcyzdjwyghqfrxwckqkxebptlpxjzsrmebwhjlbjslyysmdxlclqkx",
        "lhxjrzjmfqhxhwy",
        "wsbhtrxxglhqhfnm[ykldyxzpylgg[mtcfpajjzyljtyanjgbjplqgdzyqyaxbkysecjsznslyzhsxlzcghpxzhznytd",
        "sbcjkdlzayfmydlebbgqyzkxgldndnyskjshdlyxbcghxypkdjmmzngmmclgwzszxzjfznmlzzthcsydbdllscddnlkjy",
        "kjsycjlkwhqasdknhcsganhdaashtcplcpqybsdmpjlpzjoqlcdhjjysprchn[nnlhlyyqyhwzptczgwwmzffjqqqqyxa",
        "clbhkdjxdgmmy",
        "djxzllsygxgkjrywzwyclzmssjzldbyd[fcxyhlxchyzjq[[qagmnyxpfrkssbjlyxysyglnscmhzwwmnzjjlxxhchsy",
        "[[ttxrycyxbyhcsmxjsznpwgpxxtaybgajcxly[dccwzocwkccsbnhcpdyznfcyytyckxkybsqkkytqqxfcwchcykelzq",
        "bsqyjqcclmthsywhmktlkjlycxwheqqhtqh[pq[qscfymndmgbwhwlgsllysdlmlxpthmjhwljzyhzjxhtxjlhxrswlwz",
        "jcbxmhzqxsdzp",
        "mgfcsglsxymjshxpjxwmyqksmyplrthbxftpmhyxlchlhlzylxgsssstclsldclrpbhzhxyyfhb[gdmycnqqwlqhjj[yw",
        "jzyejjdhpblqxtqkwhlchqxagtlxljxmsl[htzkzjecxjcjnmfby[sfywybjzgnysdzsqyrsljpclpwxsdwejbjcbcnay",
        "twgmpapclyqpclzxsbnmsggfnzjjbzsfzyndxhplqkzczwalsbccjx[yzgwkypsgxfzfcdkhjgxdlqfsgdslqwzkxtmhs",
        "bgzmjzrglyjb",
        "pmlmsxlzjqqhzyjczydjwbmyklddpmjegxyhylxhlqyqhkycwcjmyyxnatjhyccxzpcqlbzwwytwbqcmlpmyrjcccxfpz",
        "nzzljplxxyztzlgdldcklyrzzgqtgjhhgjljaxfgfjzslcfdqzlclgjdjcsnzlljpjqdcclcjxmyzftsxgcgsbrzxjqqc",
        "tzhgyqtjqqlzxjylylbcyamcstylpdjbyregklzyzhlyszqlznwczcllwjqjjjkdgjzolbbzppglghtgzxyghzmycnqsyc",
        "yhbhgxkamtx",
        "yxnbskyzzgjzlqjdfcjxdygjqjjpmgwgjjjpkqsbgbmmcjssclpqpdxcdyyky[cjddyygywrhjrtgznyqldkljszzgzqz",
        "jgdykshpzmtlcpwnjafyzdjcnmwescyglbtzcgmssllyxqsxsbsjsbbsgghfjlypmzjnlyywdqshzxtyywhmzyhywdbxb",
        "tlmsyyyfsxjc[dxxlhjhf[sxzqhfzmzcztqcxzxrttdjhnnyzqqmnqdmmg[ydxmjgdhcdyzbffallztdltfxmxqzdngwq",
        "dbdczjdxbzgs",
        "qqddjcmbkzffxmkdmdsyyszcmljdsynsbrskmkmpcklgdbqtfzswtfgglyplljzhgj[gypzltcsmcnbtjbqfkthbyzgkp",
        "bbymtdssxtbnpdkleycjnyddykzddhqhsdzsctarlltkzlgecllkjlqjaqnbdkkghpjtzqksecshalqfmmgjnlyjbbtml",
        "yzxdcjpldlpcqdhzycbzsczbzmsljflkrzjsnfrgjhxpdhyjybzgdlqcsezgxlblgyxtwmabchecmwyjyzlljjyhlg[dj",
        "lslygkdzpzxj",
        "yyzlwcxszfgwyydlyhcljscmbjhblyzlycblydpdqysxqzbytdkyxjy[cnrjmpdjgklcljbctbjddbblblczqrppxjcjl",
        "zcshltoljnmdddlngkaqhqhjgykheznmshrp[qqjchgmfprxhjgdychghlyrzqlcyqjnzsqtkqjymszswlcfqqqxyfggyp",
        "tqwlmcrnfkkfsyylqbmqammmyxctpshcptxxzzsmphpshmclmldqfyqxszyydyjzzhqpdszglstjbckbxyqzjsgpsxqzq",
        "zrqtbdkyxzk",
        "hhgflbcsmdldgdzdblzyycxnncsybzbfglzzxswmsccmqnjqsbdqsjtxxmbltxzclzshzcxrqjgjylxzfjphymzqqydfq",
        "jjlzznzjcdgzygctxmzysctlkphtxhtlbjxjlxscdqxcbbtjfqzfsltjbtkqbxxjjljchczdbzjdczjdcprnpqcjpfczlc",
        "lzxzdmxmphjsgzgszzqlylwtjpfsyasmcjbtzkycwmytcsjjljcqlwzmalbxyfbpnlsfhtgjwejjxxglljstgshjqlzfkc",
        "gnnnszfdeq",
        "fhbsaqtgylbxmmygszldydqmjjrgbjtkgdhgkblqkbdmbylxwcxyttybkmrtjzxqjbhlmhmjjzmqasldcyxyqdlqcafywy",
        "xqhz"
    };
    localparam int L2_LEN = $bits(L2_ROM) / 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_empty;
    } t_out_item;

    // Front to back: an optional 'S' token, then an optional byte token
    typedef struct packed {
        logic       s_tok;
        logic       b_tok;
        logic [7:0] b;
        logic       last;
    } t_entry;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        if (b >= CHR_LC_A && b <= CHR_LC_Z) begin
            return b - CASE_GAP;
        end
        return b;
    endfunction

    function automatic logic [7:0] l2_letter(input logic [L2_IDX_W-1:0] idx);
        return L2_ROM[(L2_LEN - 1 - int'(idx)) * 8 +: 8];
    endfunction

endpackage

`default_nettype wire

// File: rtl/gpie_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gpie_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/gpie_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gpie_front import gpie_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    input  wire logic     i_full,
    output logic          o_push,
    output t_entry        o_entry
);

    logic r_held_s;
    logic n_held_s;
    logic drop;
    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign drop    = (i_item.in_byte == CHR_SPACE) || (i_item.in_byte == CHR_DASH) ||
                     (i_item.in_byte == CHR_STAR);

    always_comb begin
        o_entry.b     = i_item.in_byte;
        o_entry.last  = i_item.in_last;
        o_entry.s_tok = 1'b0;
        o_entry.b_tok = 1'b0;
        n_held_s      = r_held_s;
        if (drop) begin
            // flush a waiting S only at the end of the string
            o_entry.s_tok = i_item.in_last && r_held_s;
            n_held_s      = r_held_s && !i_item.in_last;
        end else if (i_item.in_byte == CHR_S) begin
            o_entry.s_tok = r_held_s || i_item.in_last;
            n_held_s      = !r_held_s && !i_item.in_last;
        end else begin
            o_entry.s_tok = r_held_s;
            o_entry.b_tok = 1'b1;
            n_held_s      = 1'b0;
        end
    end

    // skip beats that produce no token and do not end the string
    assign o_push = accept && (o_entry.s_tok || o_entry.b_tok || o_entry.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_s <= 1'b0;
        end else if (accept) begin
            r_held_s <= n_held_s;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gpie_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module gpie_fifo #(
    parameter int  DEPTH  = 4,
    parameter type t_data = logic
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_data i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_data      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/gpie_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gpie_back import gpie_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_pop_valid,
    input  wire t_entry i_entry,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_out_item   o_out_item
);

    typedef struct packed {
        logic [1:0]          cnt;
        logic [2:0][7:0]     bytes;
        logic                last;
        logic                empty;
        logic                rom;
        logic [L2_IDX_W-1:0] idx;
    } t_job;

    // held lead byte of a code pair
    logic       r_hv;
    logic [7:0] r_hl;

    logic        r_s1_valid;
    t_job        r_s1;
    t_job        n_s1;
    logic        r_job_valid;
    t_job        r_job;
    t_job        n_job;
    logic [1:0]  r_pos;

    // decode of one entry
    logic [2:0][7:0] d_bytes;
    logic [1:0]      d_cnt;
    logic            d_hv;
    logic [7:0]      d_hl;
    logic            d_pair;
    logic            d_empty;
    logic            d_any;

    // pair conversion
    logic [CODE_W-1:0]  c_w;
    logic signed [14:0] c_idx;
    logic [1:0]         c_cnt;
    logic [7:0]         c_b0;
    logic [7:0]         c_b1;
    logic               c_rom;

    logic done;
    logic job_free;
    logic job_load;
    logic s1_free;

    always_comb begin
        d_bytes = '0;
        d_cnt   = 2'd0;
        d_hv    = r_hv;
        d_hl    = r_hl;
        d_pair  = 1'b0;
        if (i_entry.s_tok) begin
            if (d_hv) begin
                d_bytes[d_cnt] = d_hl;
                d_cnt          = d_cnt + 2'd1;
                d_hv           = 1'b0;
            end
            d_bytes[d_cnt] = CHR_S;
            d_cnt          = d_cnt + 2'd1;
        end
        if (i_entry.b_tok) begin
            if (d_hv) begin
                if (i_entry.b >= LEAD_MIN) begin
                    d_pair = 1'b1;
                end else begin
                    // lead without a partner goes out alone
                    d_bytes[d_cnt] = d_hl;
                    d_cnt          = d_cnt + 2'd1;
                    d_bytes[d_cnt] = i_entry.b;
                    d_cnt          = d_cnt + 2'd1;
                end
                d_hv = 1'b0;
            end else if (i_entry.b >= LEAD_MIN) begin
                d_hv = 1'b1;
                d_hl = i_entry.b;
            end else begin
                d_bytes[d_cnt] = i_entry.b;
                d_cnt          = d_cnt + 2'd1;
            end
        end
        if (i_entry.last && d_hv) begin
            d_bytes[d_cnt] = d_hl;
            d_cnt          = d_cnt + 2'd1;
            d_hv           = 1'b0;
        end
        d_empty = i_entry.last && (d_cnt == 2'd0) && !d_pair;
        d_any   = d_pair || (d_cnt != 2'd0) || d_empty;
    end

    assign c_w   = CODE_W'((int'(r_hl) - ZONE_BIAS) * ZONE_MUL + int'(i_entry.b) - ZONE_BIAS);
    assign c_idx = 15'((int'(r_hl) - ZONE_BIAS - L2_ROW0) * L2_ROW_LEN +
                       int'(i_entry.b) - L2_COL0);

    always_comb begin
        c_cnt = 2'd1;
        c_b0  = r_hl;
        c_b1  = i_entry.b;
        c_rom = 1'b0;
        if (c_w inside {[DIGIT_LO:DIGIT_HI]}) begin
            c_b0 = 8'(int'(CHR_0) + int'(c_w) - DIGIT_LO);
        end else if (c_w inside {[LETTER_LO:LETTER_HI]}) begin
            c_b0 = 8'(int'(CHR_A) + int'(c_w) - LETTER_LO);
        end else if (c_w inside {[L1_LO:L1_END-1]}) begin
            c_b0 = BOUND_LETTER[0];
            for (int j = 1; j < NUM_BOUNDS; j++) begin
                if (c_w >= BOUND_CODE[j]) begin
                    c_b0 = BOUND_LETTER[j];
                end
            end
        end else if (c_idx >= 0 && c_idx <= L2_MAX && c_idx < L2_LEN) begin
            c_rom = 1'b1;
        end else begin
            c_cnt = 2'd2;
        end
    end

    always_comb begin
        n_s1       = '0;
        n_s1.last  = i_entry.last;
        n_s1.empty = d_empty;
        n_s1.idx   = c_idx[L2_IDX_W-1:0];
        if (d_pair) begin
            n_s1.cnt      = c_cnt;
            n_s1.bytes[0] = c_b0;
            n_s1.bytes[1] = c_b1;
            n_s1.rom      = c_rom;
        end else if (d_empty) begin
            n_s1.cnt = 2'd1;
        end else begin
            n_s1.cnt   = d_cnt;
            n_s1.bytes = d_bytes;
        end
    end

    // job register drains one result per beat
    assign done     = r_job_valid && i_out_ready && (r_pos == r_job.cnt - 2'd1);
    assign job_free = !r_job_valid || done;
    assign job_load = r_s1_valid && job_free;
    assign s1_free  = !r_s1_valid || job_free;
    assign o_pop    = i_pop_valid && s1_free;

    always_comb begin
        n_job = r_s1;
        if (r_s1.rom) begin
            n_job.bytes[0] = l2_letter(r_s1.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hl <= d_hl;
            r_s1 <= n_s1;
        end
        if (job_load) begin
            r_job <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv        <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_job_valid <= 1'b0;
            r_pos       <= 2'd0;
        end else begin
            if (o_pop) begin
                r_hv       <= d_hv;
                r_s1_valid <= d_any;
            end else if (job_load) begin
                r_s1_valid <= 1'b0;
            end
            if (job_load) begin
                r_job_valid <= 1'b1;
                r_pos       <= 2'd0;
            end else if (done) begin
                r_job_valid <= 1'b0;
                r_pos       <= 2'd0;
            end else if (r_job_valid && i_out_ready) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    assign o_out_valid          = r_job_valid;
    assign o_out_item.out_byte  = upcase(r_job.bytes[r_pos]);
    assign o_out_item.out_last  = r_job.last && (r_pos == r_job.cnt - 2'd1);
    assign o_out_item.out_empty = r_job.empty;

endmodule

`default_nettype wire

// File: rtl/gb2312_pinyin_initial_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts a GB2312 byte string, one byte per beat, into an uppercase string of pinyin
// initials: spaces, dashes and asterisks are dropped, "SS" collapses to "S", full-width
// digits and letters become ASCII, hanzi become their initial letter, other code pairs and
// lone bytes pass through, and the last result of a string carries out_last (a string that
// yields nothing gives one out_empty marker). The input takes one byte every cycle while
// the queue is not full; each input byte yields zero to three result beats, and the output
// side sends one result beat per cycle from its job register while the sink is ready, so
// sustained throughput is one byte per cycle whenever each byte yields at most one result.
// The first result of a byte passes the queue write, the decode/convert stage and the job
// register holding the level-2 table read before it is offered.
module gb2312_pinyin_initial_encoder import gpie_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    gpie_stream_if.sink    i_in,
    gpie_stream_if.source  o_out
);

    logic      push;
    t_entry    push_entry;
    logic      fifo_full;
    logic      fifo_valid;
    t_entry    fifo_entry;
    logic      pop;
    t_in_item  in_item;
    t_out_item out_item;

    assign in_item = i_in.payload;

    gpie_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .i_full  (fifo_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    gpie_fifo #(
        .DEPTH  (FIFO_DEPTH),
        .t_data (t_entry)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_data  (fifo_entry)
    );

    gpie_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (fifo_valid),
        .i_entry     (fifo_entry),
        .o_pop       (pop),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );

    assign o_out.payload = out_item;

endmodule

`default_nettype wire

// File: rtl/gpie_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "gb2312_pinyin_initial_encoder_assert.svh"

module gpie_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last,
    input wire logic       i_out_empty
);

    `GPIE_ASSERT_IMP(a_empty_marker, i_clk, i_rst_n, i_out_valid && i_out_empty, i_out_last && (i_out_byte == 8'h00), "end marker without last or with data")

    `GPIE_ASSERT_IMP(a_no_lowercase, i_clk, i_rst_n, i_out_valid, !((i_out_byte >= 8'h61) && (i_out_byte <= 8'h7a)), "lowercase byte on output")

    `GPIE_ASSERT_IMP(a_no_dropped, i_clk, i_rst_n, i_out_valid, (i_out_byte != 8'h20) && (i_out_byte != 8'h2d) && (i_out_byte != 8'h2a), "dropped byte reached output")

    `GPIE_ASSERT_NXT(a_hold_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last) && $stable(i_out_empty), "stalled result changed")

endmodule

bind gb2312_pinyin_initial_encoder gpie_checker u_gpie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.payload.out_byte),
    .i_out_last  (o_out.payload.out_last),
    .i_out_empty (o_out.payload.out_empty)
);

`default_nettype wire

// File: tb/gpie_initials_checker.sv
`timescale 1ns / 1ps

module gpie_initials_checker import gpie_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_results
);

    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DASH  = 8'h2d;
    localparam logic [7:0] BYTE_STAR  = 8'h2a;
    localparam logic [7:0] BYTE_S     = 8'h53;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_UC_A  = 8'h41;
    localparam logic [7:0] BYTE_LC_A  = 8'h61;
    localparam logic [7:0] BYTE_LC_Z  = 8'h7a;
    localparam logic [7:0] UPCASE_SUB = 8'h20;
    localparam logic [7:0] LEAD_FLOOR = 8'ha1;

    localparam int ROW_BIAS        = 160;
    localparam int ZONE_SCALE      = 100;
    localparam int FW_DIGIT_FIRST  = 316;
    localparam int FW_DIGIT_LAST   = 325;
    localparam int FW_LETTER_FIRST = 333;
    localparam int FW_LETTER_LAST  = 358;
    localparam int HANZI1_FIRST    = 1601;
    localparam int HANZI1_END      = 5590;
    localparam int HANZI2_LEAD     = 216;
    localparam int HANZI2_ROW_LEN  = 94;
    localparam int HANZI2_COL0     = 161;
    localparam int HANZI2_LAST     = 3007;
    localparam int MAX_REPORTS     = 10;

    // Level-2 hanzi initials, row 0x D8 first, 94 entries per row
    string l2_initials;

    initial begin
        l2_initials = {
            "cjwgnspgcgne[y[btyyzdxykygt[jnnjqmbsgzscyjsyy[pgkbzgy",
            "[ywjkgkljywkpjqhy[w[dzlsgmrypywwcckznkyygttnjjnykkzytc",
            "jnmcylqlypyqfqrpzslwbtgkjfyxjwzltbncxjjjjtxdttsqzycdxx",
            "hgck[phffss[ybgxlppbyll[hlxs[zm[jhsojnghdzqyklgjhsgqzh",
            "xqgkezzwyscscjxyeyxadzpmdssmzjzqjyzc[j[wqjbyzpxgznzcpw",
            "hkxhqkmwfbpbydtjzzkqhy",
            "lygxfptyjyyzpszlfchmqshgmxxsxj[[dcsbbqbefsjyhxwgzkpy",
            "lqbgldlcctnmayddkssngycsgxlyzaybnptsdkdylhgymylcxpy[j",
            "ndqjwxqxfyyfjlejpzrxccqwqqsbnkymgplbmjrqcflnymyqmsqyr",
            "bcjthztqfrxqhxmjjcjlxqgjmshzkbswyemyltxfsydswlycjqxsj",
            "nqbsctyhbftdcyzdjwyghqfrxwckqkxebptlpxjzsrmebwhjlbjsl",
            "yysmdxlclqkxlhxjrzjmfqhxhwy",
            "wsbhtrxxglhqhfnm[ykldyxzpylgg[mtcfpajjzyljtyanjgbjpl",
            "qgdzyqyaxbkysecjsznslyzhsxlzcghpxzhznytdsbcjkdlzayfmy",
            "dlebbgqyzkxgldndnyskjshdlyxbcghxypkdjmmzngmmclgwzszxz",
            "jfznmlzzthcsydbdllscddnlkjykjsycjlkwhqasdknhcsganhdaa",
            "shtcplcpqybsdmpjlpzjoqlcdhjjysprchn[nnlhlyyqyhwzptczg",
            "wwmzffjqqqqyxaclbhkdjxdgmmy",
            "djxzllsygxgkjrywzwyclzmssjzldbyd[fcxyhlxchyzjq[[qagm",
            "nyxpfrkssbjlyxysyglnscmhzwwmnzjjlxxhchsy[[ttxrycyxbyh",
            "csmxjsznpwgpxxtaybgajcxly[dccwzocwkccsbnhcpdyznfcyyty",
            "ckxkybsqkkytqqxfcwchcykelzqbsqyjqcclmthsywhmktlkjlycx",
            "wheqqhtqh[pq[qscfymndmgbwhwlgsllysdlmlxpthmjhwljzyhzj",
            "xhtxjlhxrswlwzjcbxmhzqxsdzp",
            "mgfcsglsxymjshxpjxwmyqksmyplrthbxftpmhyxlchlhlzylxgs",
            "ssstclsldclrpbhzhxyyfhb[gdmycnqqwlqhjj[ywjzyejjdhpblq",
            "xtqkwhlchqxagtlxljxmsl[htzkzjecxjcjnmfby[sfywybjzgnys",
            "dzsqyrsljpclpwxsdwejbjcbcnaytwgmpapclyqpclzxsbnmsggfn",
            "zjjbzsfzyndxhplqkzczwalsbccjx[yzgwkypsgxfzfcdkhjgxdlq",
            "fsgdslqwzkxtmhsbgzmjzrglyjb",
            "pmlmsxlzjqqhzyjczydjwbmyklddpmjegxyhylxhlqyqhkycwcjm",
            "yyxnatjhyccxzpcqlbzwwytwbqcmlpmyrjcccxfpznzzljplxxyzt",
            "zlgdldcklyrzzgqtgjhhgjljaxfgfjzslcfdqzlclgjdjcsnzlljp",
            "jqdcclcjxmyzftsxgcgsbrzxjqqctzhgyqtjqqlzxjylylbcyamcs",
            "tylpdjbyregklzyzhlyszqlznwczcllwjqjjjkdgjzolbbzppglgh",
            "tgzxyghzmycnqsycyhbhgxkamtx",
            "yxnbskyzzgjzlqjdfcjxdygjqjjpmgwgjjjpkqsbgbmmcjssclpq",
            "pdxcdyyky[cjddyygywrhjrtgznyqldkljszzgzqzjgdykshpzmtl",
            "cpwnjafyzdjcnmwescyglbtzcgmssllyxqsxsbsjsbbsgghfjlypm",
            "zjnlyywdqshzxtyywhmzyhywdbxbtlmsyyyfsxjc[dxxlhjhf[sxz",
            "qhfzmzcztqcxzxrttdjhnnyzqqmnqdmmg[ydxmjgdhcdyzbffallz",
            "tdltfxmxqzdngwqdbdczjdxbzgs",
            "qqddjcmbkzffxmkdmdsyyszcmljdsynsbrskmkmpcklgdbqtfzsw",
            "tfgglyplljzhgj[gypzltcsmcnbtjbqfkthbyzgkpbbymtdssxtbn",
            "pdkleycjnyddykzddhqhsdzsctarlltkzlgecllkjlqjaqnbdkkgh",
            "pjtzqksecshalqfmmgjnlyjbbtmlyzxdcjpldlpcqdhzycbzsczbz",
            "msljflkrzjsnfrgjhxpdhyjybzgdlqcsezgxlblgyxtwmabchecmw",
            "yjyzlljjyhlg[djlslygkdzpzxj",
            "yyzlwcxszfgwyydlyhcljscmbjhblyzlycblydpdqysxqzbytdky",
            "xjy[cnrjmpdjgklcljbctbjddbblblczqrppxjcjlzcshltoljnmd",
            "ddlngkaqhqhjgykheznmshrp[qqjchgmfprxhjgdychghlyrzqlcy",
            "qjnzsqtkqjymszswlcfqqqxyfggyptqwlmcrnfkkfsyylqbmqammm",
            "yxctpshcptxxzzsmphpshmclmldqfyqxszyydyjzzhqpdszglstjb",
            "ckbxyqzjsgpsxqzqzrqtbdkyxzk",
            "hhgflbcsmdldgdzdblzyycxnncsybzbfglzzxswmsccmqnjqsbdq",
            "sjtxxmbltxzclzshzcxrqjgjylxzfjphymzqqydfqjjlzznzjcdgz",
            "ygctxmzysctlkphtxhtlbjxjlxscdqxcbbtjfqzfsltjbtkqbxxjj",
            "ljchczdbzjdczjdcprnpqcjpfczlclzxzdmxmphjsgzgszzqlylwt",
            "jpfsyasmcjbtzkycwmytcsjjljcqlwzmalbxyfbpnlsfhtgjwejjx",
            "xglljstgshjqlzfkcgnnnszfdeq",
            "fhbsaqtgylbxmmygszldydqmjjrgbjtkgdhgkblqkbdmbylxwcxy",
            "ttybkmrtjzxqjbhlmhmjjzmqasldcyxyqdlqcafywyxqhz"
        };
    end

    t_out_item  expected_chars[$];
    logic       s_waiting;
    logic       lead_waiting;
    logic [7:0] lead_byte;
    int         step_beats;
    int         mismatches;
    int         beats_seen;

    function automatic logic [7:0] hanzi1_initial(input int code);
        if (code >= 5249) return "Z";
        if (code >= 4925) return "Y";
        if (code >= 4684) return "X";
        if (code >= 4558) return "W";
        if (code >= 4390) return "T";
        if (code >= 4086) return "S";
        if (code >= 4027) return "R";
        if (code >= 3858) return "Q";
        if (code >= 3730) return "P";
        if (code >= 3722) return "O";
        if (code >= 3635) return "N";
        if (code >= 3472) return "M";
        if (code >= 3212) return "L";
        if (code >= 3106) return "K";
        if (code >= 2787) return "J";
        if (code >= 2594) return "H";
        if (code >= 2433) return "G";
        if (code >= 2302) return "F";
        if (code >= 2274) return "E";
        if (code >= 2078) return "D";
        if (code >= 1833) return "C";
        if (code >= 1637) return "B";
        return "A";
    endfunction

    function automatic void push_char(input logic [7:0] b);
        t_out_item r;
        r.out_byte  = (b >= BYTE_LC_A && b <= BYTE_LC_Z) ? b - UPCASE_SUB : b;
        r.out_last  = 1'b0;
        r.out_empty = 1'b0;
        expected_chars.push_back(r);
        step_beats++;
    endfunction

    function automatic void convert_code_pair(input logic [7:0] hi, input logic [7:0] lo);
        int zone;
        int rom_idx;
        zone = (int'(hi) - ROW_BIAS) * ZONE_SCALE + int'(lo) - ROW_BIAS;
        rom_idx = (int'(hi) - HANZI2_LEAD) * HANZI2_ROW_LEN + int'(lo) - HANZI2_COL0;
        if (zone >= FW_DIGIT_FIRST && zone <= FW_DIGIT_LAST) begin
            push_char(BYTE_ZERO + 8'(zone - FW_DIGIT_FIRST));
        end else if (zone >= FW_LETTER_FIRST && zone <= FW_LETTER_LAST) begin
            push_char(BYTE_UC_A + 8'(zone - FW_LETTER_FIRST));
        end else if (zone >= HANZI1_FIRST && zone < HANZI1_END) begin
            push_char(hanzi1_initial(zone));
        end else if (rom_idx >= 0 && rom_idx <= HANZI2_LAST && rom_idx < l2_initials.len()) begin
            push_char(l2_initials[rom_idx]);
        end else begin
            push_char(hi);
            push_char(lo);
        end
    endfunction

    // Pair high bytes, pass everything else straight through
    function automatic void pair_stage(input logic [7:0] b);
        logic [7:0] hi;
        if (lead_waiting) begin
            hi = lead_byte;
            lead_waiting = 1'b0;
            lead_byte = '0;
            if (b >= LEAD_FLOOR) begin
                convert_code_pair(hi, b);
            end else begin
                push_char(hi);
                push_char(b);
            end
        end else if (b >= LEAD_FLOOR) begin
            lead_waiting = 1'b1;
            lead_byte = b;
        end else begin
            push_char(b);
        end
    endfunction

    function automatic void encode_input_byte(input logic [7:0] b, input logic last);
        t_out_item tail;
        step_beats = 0;
        if (b != BYTE_SPACE && b != BYTE_DASH && b != BYTE_STAR) begin
            if (b == BYTE_S && !s_waiting) begin
                s_waiting = 1'b1;
            end else if (b == BYTE_S) begin
                s_waiting = 1'b0;
                pair_stage(BYTE_S);
            end else begin
                if (s_waiting) begin
                    s_waiting = 1'b0;
                    pair_stage(BYTE_S);
                end
                pair_stage(b);
            end
        end
        if (last) begin
            if (s_waiting) begin
                s_waiting = 1'b0;
                pair_stage(BYTE_S);
            end
            if (lead_waiting) begin
                push_char(lead_byte);
                lead_waiting = 1'b0;
                lead_byte = '0;
            end
            if (step_beats == 0) begin
                tail.out_byte  = '0;
                tail.out_last  = 1'b1;
                tail.out_empty = 1'b1;
                expected_chars.push_back(tail);
            end else begin
                tail = expected_chars.pop_back();
                tail.out_last = 1'b1;
                expected_chars.push_back(tail);
            end
        end
    endfunction

    function automatic void flag_beat(input string why, input t_out_item want,
                                      input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %02h last %b empty %b, got %02h last %b empty %b",
                     $realtime, why, want.out_byte, want.out_last, want.out_empty,
                     got.out_byte, got.out_last, got.out_empty);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            s_waiting    = 1'b0;
            lead_waiting = 1'b0;
            lead_byte    = '0;
            expected_chars.delete();
        end else begin
            // check outputs first: a beat can never come from the byte taken at this edge
            if (i_out_valid && i_out_ready) begin
                beats_seen++;
                if (expected_chars.size() == 0) begin
                    flag_beat("unexpected beat", '0, i_out_item);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_item.out_byte !== want.out_byte
                            || i_out_item.out_last !== want.out_last
                            || i_out_item.out_empty !== want.out_empty) begin
                        flag_beat("wrong beat", want, i_out_item);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                encode_input_byte(i_in_item.in_byte, i_in_item.in_last);
            end
        end
        o_pending    <= expected_chars.size();
        o_mismatches <= mismatches;
        o_results    <= beats_seen;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import gpie_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_BYTES   = 155;
    localparam int CALM_TAIL      = 35;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    gpie_stream_if #(.t_payload(t_in_item))  in_ch ();
    gpie_stream_if #(.t_payload(t_out_item)) out_ch ();

    int         mismatches;
    int         pending;
    int         results;
    int         bytes_sent;
    int         strings_sent;
    int         stall_cycles;
    bit         calm_tail;
    logic [7:0] text_buf[$];

    gb2312_pinyin_initial_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gpie_initials_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_item    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_item   (out_ch.payload),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hold one beat until taken, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= {b, last};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic compose_random_text();
        int tokens;
        tokens = $urandom_range(1, 8);
        text_buf.delete();
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // hanzi, level 1 or level 2 and a little past the table
                    text_buf.push_back(8'($urandom_range(8'hb0, 8'hf8)));
                    text_buf.push_back(8'($urandom_range(8'ha1, 8'hfe)));
                end
                3: begin
                    text_buf.push_back(8'ha3);
                    if ($urandom_range(0, 1) == 0) begin
                        text_buf.push_back(8'($urandom_range(8'hb0, 8'hb9)));
                    end else begin
                        text_buf.push_back(8'($urandom_range(8'hc1, 8'hda)));
                    end
                end
                4: text_buf.push_back(8'($urandom_range(8'h30, 8'h7e)));
                5: begin
                    text_buf.push_back(CHR_S);
                    if ($urandom_range(0, 1) == 0) text_buf.push_back(CHR_S);
                end
                6: begin
                    case ($urandom_range(0, 2))
                        0: text_buf.push_back(CHR_SPACE);
                        1: text_buf.push_back(CHR_DASH);
                        default: text_buf.push_back(CHR_STAR);
                    endcase
                end
                7: begin
                    text_buf.push_back(8'($urandom_range(8'ha1, 8'hff)));
                    text_buf.push_back(8'($urandom_range(8'ha1, 8'hff)));
                end
                8: text_buf.push_back(8'($urandom_range(0, 255)));
                default: begin
                    // broken pair: high byte then a low one
                    text_buf.push_back(8'($urandom_range(8'ha1, 8'hff)));
                    text_buf.push_back(8'($urandom_range(0, 8'ha0)));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            text_buf.push_back(8'($urandom_range(8'ha1, 8'hff)));
        end
    endtask

    // Sink side: stall bursts, or always ready once the tail starts
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm_tail && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                     stall_cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int random_start;
        calm_tail     = 1'b0;
        bytes_sent    = 0;
        strings_sent  = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-dropped string gives the empty marker
        text_buf = '{CHR_DASH};
        send_text();
        // SS pairing, then a lone S flushed at the end
        text_buf = '{CHR_S, CHR_S, CHR_S};
        send_text();
        // held S released by another byte, lowercase, drops, zero byte
        text_buf = '{CHR_S, CHR_LC_A, CHR_SPACE, CHR_STAR, 8'h00};
        send_text();
        // full-width digit and letters
        text_buf = '{8'ha3, 8'hb0, 8'ha3, 8'hc1, 8'ha3, 8'hda};
        send_text();
        // level-1 first code, level-2 no-initial entry, level-2 last code,
        // code just past level 1, high byte before a low byte, trailing high byte
        text_buf = '{8'hb0, 8'ha1, 8'hd8, 8'had, 8'hf7, 8'hfe, 8'hd7, 8'hfa,
                     8'hff, CHR_A, 8'hc8};
        send_text();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (bytes_sent - random_start >= RANDOM_BYTES - CALM_TAIL) calm_tail = 1'b1;
            compose_random_text();
            send_text();
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d strings (%0d bytes), checked %0d result beats, %0d mismatches.",
                 strings_sent, bytes_sent, results, mismatches);
        $display("Covered drops, S pairing, full-width, both hanzi levels, broken pairs, stalls.");
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
